/* sv/frame_checker_crc32c_top_assert.svh */
// Assertion macros for the frame checker with CRC-32C.
// Used by frame_checker_crc32c_top; expects signals clk and rst_n in scope.
`ifndef FRAME_CHECKER_CRC32C_TOP_ASSERT_SVH
`define FRAME_CHECKER_CRC32C_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define FCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fcc_pkg.sv */
// Package for the frame checker with CRC-32C: constants, types and the
// byte-wide CRC-32C update. No dependencies.
`default_nettype none

package fcc_pkg;

  localparam logic [31:0] CRC_POLY = 32'h82f6_3b78;
  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] HDR_SIZE     = POS_W'(20);
  localparam logic [4:0]       HDR_CRC_END  = 5'd18;

  // Header byte offsets.
  localparam logic [4:0] OFS_VERSION  = 5'd4;
  localparam logic [4:0] OFS_TYPE     = 5'd5;
  localparam logic [4:0] OFS_FLAGS    = 5'd6;
  localparam logic [4:0] OFS_SEQUENCE = 5'd8;
  localparam logic [4:0] OFS_NONCE    = 5'd12;
  localparam logic [4:0] OFS_LENGTH   = 5'd16;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SHORT   = 3'd1;
  localparam logic [2:0] ERR_MAGIC   = 3'd2;
  localparam logic [2:0] ERR_VERSION = 3'd3;
  localparam logic [2:0] ERR_LENGTH  = 3'd4;
  localparam logic [2:0] ERR_CHECK   = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAY = 2'd2;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [7:0]  expected_version;
    logic [15:0] max_payload;
  } fcc_cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [7:0]  msg_type;
    logic [15:0] msg_flags;
    logic [31:0] sequence_number;
    logic [31:0] nonce_value;
    logic [15:0] payload_count;
  } fcc_result_t;

  // Reflected CRC-32C update by one byte.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/fcc_channels.sv */
// Handshake channel interfaces for the frame checker: byte input, result
// output and configuration write. Depends on fcc_pkg.
`default_nettype none

interface fcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;
  modport source(output valid, byte_in, last_byte, input ready);
  modport sink(input valid, byte_in, last_byte, output ready);
endinterface

interface fcc_result_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        frame_end;
  logic        frame_ok;
  logic [2:0]  error_code;
  logic [7:0]  msg_type;
  logic [15:0] msg_flags;
  logic [31:0] sequence_number;
  logic [31:0] nonce_value;
  logic [15:0] payload_count;
  modport source(output valid, payload_valid, payload_byte, frame_end, frame_ok,
                 error_code, msg_type, msg_flags, sequence_number, nonce_value,
                 payload_count, input ready);
  modport sink(input valid, payload_valid, payload_byte, frame_end, frame_ok,
               error_code, msg_type, msg_flags, sequence_number, nonce_value,
               payload_count, output ready);
endinterface

interface fcc_cfg_if import fcc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/fcc_parse.sv */
// Frame state of the checker: header capture, the two CRC-32C registers,
// the byte counter and the verdict for the current byte. Depends on fcc_pkg.
`default_nettype none

module fcc_parse import fcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_byte,
  input  wire fcc_cfg_t    cfg,
  output logic             emit,
  output fcc_result_t      res
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] hcrc_r, hcrc_nxt;
  logic [31:0] pcrc_r, pcrc_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] nonce_r, nonce_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] chk_r, chk_nxt;

  logic        is_pay;
  logic [4:0]  p_lo;
  logic [31:0] crc_x;
  logic [15:0] fold;
  logic [2:0]  err;

  assign is_pay = (pos_r >= HDR_SIZE);
  assign p_lo   = pos_r[4:0];

  always_comb begin
    hcrc_nxt  = hcrc_r;
    pcrc_nxt  = pcrc_r;
    magic_nxt = magic_r;
    ver_nxt   = ver_r;
    type_nxt  = type_r;
    flags_nxt = flags_r;
    seq_nxt   = seq_r;
    nonce_nxt = nonce_r;
    len_nxt   = len_r;
    chk_nxt   = chk_r;
    if (is_pay) begin
      pcrc_nxt = crc32c_byte(pcrc_r, byte_in);
    end else begin
      if (p_lo < HDR_CRC_END) begin
        hcrc_nxt = crc32c_byte(hcrc_r, byte_in);
      end
      if (p_lo < OFS_VERSION) begin
        magic_nxt = {byte_in, magic_r[31:8]};
      end else if (p_lo == OFS_VERSION) begin
        ver_nxt = byte_in;
      end else if (p_lo == OFS_TYPE) begin
        type_nxt = byte_in;
      end else if (p_lo < OFS_SEQUENCE) begin
        flags_nxt[p_lo[0]*8 +: 8] = byte_in;
      end else if (p_lo < OFS_NONCE) begin
        seq_nxt[p_lo[1:0]*8 +: 8] = byte_in;
      end else if (p_lo < OFS_LENGTH) begin
        nonce_nxt[p_lo[1:0]*8 +: 8] = byte_in;
      end else if (p_lo < HDR_CRC_END) begin
        len_nxt[p_lo[0]*8 +: 8] = byte_in;
      end else begin
        chk_nxt[p_lo[0]*8 +: 8] = byte_in;
      end
    end
    pos_nxt = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;
  end

  assign crc_x = hcrc_nxt ^ pcrc_nxt;
  assign fold  = crc_x[15:0] ^ crc_x[31:16];

  always_comb begin
    if (pos_nxt < HDR_SIZE) begin
      err = ERR_SHORT;
    end else if (magic_nxt != cfg.expected_magic) begin
      err = ERR_MAGIC;
    end else if (ver_nxt != cfg.expected_version) begin
      err = ERR_VERSION;
    end else if ((len_nxt > cfg.max_payload) ||
                 (pos_nxt != HDR_SIZE + POS_W'(len_nxt))) begin
      err = ERR_LENGTH;
    end else if (fold != chk_nxt) begin
      err = ERR_CHECK;
    end else begin
      err = ERR_NONE;
    end
  end

  assign emit = is_pay || last_byte;

  always_comb begin
    res = '0;
    res.payload_valid = is_pay;
    res.payload_byte  = is_pay ? byte_in : 8'd0;
    if (last_byte) begin
      res.frame_end       = 1'b1;
      res.frame_ok        = (err == ERR_NONE);
      res.error_code      = err;
      res.msg_type        = type_nxt;
      res.msg_flags       = flags_nxt;
      res.sequence_number = seq_nxt;
      res.nonce_value     = nonce_nxt;
      res.payload_count   = len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r   <= '0;
      hcrc_r  <= CRC_INIT;
      pcrc_r  <= CRC_INIT;
      magic_r <= '0;
      ver_r   <= '0;
      type_r  <= '0;
      flags_r <= '0;
      seq_r   <= '0;
      nonce_r <= '0;
      len_r   <= '0;
      chk_r   <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      hcrc_r  <= hcrc_nxt;
      pcrc_r  <= pcrc_nxt;
      magic_r <= magic_nxt;
      ver_r   <= ver_nxt;
      type_r  <= type_nxt;
      flags_r <= flags_nxt;
      seq_r   <= seq_nxt;
      nonce_r <= nonce_nxt;
      len_r   <= len_nxt;
      chk_r   <= chk_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/frame_checker_crc32c_top.sv */
// Top level of the frame checker with CRC-32C: input register, frame state,
// result register and configuration registers. Depends on fcc_pkg,
// fcc_channels, fcc_parse and frame_checker_crc32c_top_assert.svh.
`default_nettype none
`include "frame_checker_crc32c_top_assert.svh"

// The checker takes one frame byte per cycle while in_bus.ready is high and
// passes it on through the input register, where the byte-wide CRC-32C
// update, header capture and verdict are worked out, and then through the
// result register. Header bytes other than the last byte of a frame give
// no result; every payload byte gives one, and the last byte carries the
// verdict. A stalled result stops the input only once both registers are
// full. Configuration writes are always taken and should be made only
// while no frame is in flight.
module frame_checker_crc32c_top import fcc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  fcc_byte_if.sink     in_bus,
  fcc_result_if.source out_bus,
  fcc_cfg_if.sink      cfg_bus
);

  fcc_cfg_t    cfg_r;
  logic        s0_valid_r;
  logic [7:0]  s0_byte_r;
  logic        s0_last_r;
  logic        out_valid_r, out_valid_nxt;
  fcc_result_t out_r;
  fcc_result_t res;
  logic        emit;
  logic        out_free;
  logic        s0_go;
  logic        in_take;

  assign out_free = !out_valid_r || out_bus.ready;
  assign s0_go    = s0_valid_r && (!emit || out_free);
  assign in_bus.ready = !s0_valid_r || s0_go;
  assign in_take  = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  fcc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s0_go),
    .byte_in   (s0_byte_r),
    .last_byte (s0_last_r),
    .cfg       (cfg_r),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic   <= 32'd0;
      cfg_r.expected_version <= 8'd1;
      cfg_r.max_payload      <= 16'd512;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_MAGIC:   cfg_r.expected_magic   <= cfg_bus.data;
        REG_VERSION: cfg_r.expected_version <= cfg_bus.data[7:0];
        REG_MAX_PAY: cfg_r.max_payload      <= cfg_bus.data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s0_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_byte_r <= in_bus.byte_in;
      s0_last_r <= in_bus.last_byte;
    end
  end

  always_comb begin
    if (s0_go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && emit) begin
      out_r <= res;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.payload_valid   = out_r.payload_valid;
  assign out_bus.payload_byte    = out_r.payload_byte;
  assign out_bus.frame_end       = out_r.frame_end;
  assign out_bus.frame_ok        = out_r.frame_ok;
  assign out_bus.error_code      = out_r.error_code;
  assign out_bus.msg_type        = out_r.msg_type;
  assign out_bus.msg_flags       = out_r.msg_flags;
  assign out_bus.sequence_number = out_r.sequence_number;
  assign out_bus.nonce_value     = out_r.nonce_value;
  assign out_bus.payload_count   = out_r.payload_count;

  `FCC_ASSERT_IMPL(a_result_kind, out_valid_r, out_r.payload_valid || out_r.frame_end, "result is neither payload nor verdict")
  `FCC_ASSERT_IMPL(a_ok_matches_code, out_valid_r && out_r.frame_end, out_r.frame_ok == (out_r.error_code == ERR_NONE), "frame_ok disagrees with error_code")
  `FCC_ASSERT_IMPL(a_no_verdict_fields, out_valid_r && !out_r.frame_end, !out_r.frame_ok && out_r.error_code == ERR_NONE, "verdict fields set on a payload beat")
  `FCC_ASSERT_NEXT(a_held_byte, s0_valid_r && !s0_go, s0_valid_r && $stable(s0_byte_r), "held input byte was dropped")
  `FCC_ASSERT_NEXT(a_cfg_magic, cfg_bus.valid && cfg_bus.index == REG_MAGIC, cfg_r.expected_magic == $past(cfg_bus.data), "magic register not written")

endmodule

`default_nettype wire
